// File: rtl/rpn_stack_evaluator_defines.svh
// Assertion macros shared by the checker file
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define RPN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define RPN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rpn_pkg.sv
package rpn_pkg;

   // data path and stack sizing
   localparam int WORD_W      = 32;
   localparam int TOKEN_W     = 8;
   localparam int STATUS_W    = 3;
   localparam int STACK_DEPTH = 32;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ITER_W      = $clog2(WORD_W);

   localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(WORD_W - 1);
   localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(STACK_DEPTH);

   // token characters
   localparam logic [TOKEN_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [TOKEN_W-1:0] CH_NINE  = 8'h39;
   localparam logic [TOKEN_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [TOKEN_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [TOKEN_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [TOKEN_W-1:0] CH_SLASH = 8'h2F;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_LENGTH    = 3'd1,
      STS_UNDERFLOW = 3'd2,
      STS_DIVZERO   = 3'd3,
      STS_INVALID   = 3'd4,
      STS_DEPTH     = 3'd5,
      STS_OVERFLOW  = 3'd6
   } status_type;

   // operator codes
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_OPND = 7'b0000010,
      ST_ABSA = 7'b0000100,
      ST_ABSB = 7'b0001000,
      ST_ITER = 7'b0010000,
      ST_FIX  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

endpackage

// File: rtl/rpn_stack_evaluator.sv
// RPN expression evaluator.
// Input channel req_*: one token per transfer; req_tdata is the token character,
// req_tuser flags a token of bad length, req_tlast marks the final token.
// Result channel rsp_*: one transfer per expression, sent after the final token;
// rsp_tuser carries the status code, rsp_tdata the 32-bit value (zero on error).
// The block works on one token at a time and drops req_tready while busy.
// Digit, bad and ignored tokens are done in the accepting cycle; + and - add
// in ST_OPND; * and / iterate in ST_ITER (/ stops in ST_OPND on a zero divisor);
// after the final token the result register is loaded in ST_FIN.
// Multiply and divide run one bit per cycle through the single shared 33-bit
// adder (shift-add and restoring divide).
// The top of stack lives in a register; the entries below it live in a RAM with
// one registered read port, so an operator's RAM read returns in ST_OPND.
// A synchronous reset empties the stack, clears the latched error and drops
// rsp_tvalid. When the receiver stalls, the result is held in the output
// register and the block keeps taking tokens; a second final token waits
// until the held result has been transferred.
module rpn_stack_evaluator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rpn_pkg::TOKEN_W-1:0]  req_tdata,  // [7:0] token_char
   input  logic                         req_tuser,  // [0] bad_length
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [rpn_pkg::WORD_W-1:0]   rsp_tdata,  // [31:0] value
   output logic [rpn_pkg::STATUS_W-1:0] rsp_tuser   // [2:0] status
);

   import rpn_pkg::*;

   // control state
   state_type         state_ff,     state_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   status_type        err_ff,       err_in;
   logic [ITER_W-1:0] iter_ff,      iter_in;
   op_type            op_ff,        op_in;
   logic              last_ff,      last_in;
   logic              negq_ff,      negq_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [WORD_W-1:0] tos_ff,       tos_in;
   logic [WORD_W-1:0] acc_ff,       acc_in;
   logic [WORD_W-1:0] wa_ff,        wa_in;
   logic [WORD_W-1:0] wb_ff,        wb_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;

   // shared adder
   logic [WORD_W-1:0] add_x;
   logic [WORD_W-1:0] add_y;
   logic              add_sub;
   logic [WORD_W:0]   add_sum;

   // stack RAM
   logic              wr_en;
   logic              rd_en;
   logic [WORD_W-1:0] rd_data;
   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W-1:0]  cnt_m2;

   // token decode
   logic              is_digit;
   logic              is_op;
   op_type            tok_op;
   state_type         done_state;
   logic [WORD_W-1:0] div_shift;

   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);

   rpn_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_m1[ADDR_W-1:0]),
      .wr_data (tos_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_m2[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {WORD_W{add_sub}}} + (WORD_W + 1)'(add_sub);

   // character classes
   assign is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign is_op    = (req_tdata == CH_PLUS) || (req_tdata == CH_MINUS) ||
                     (req_tdata == CH_STAR) || (req_tdata == CH_SLASH);

   always_comb begin
      unique case (req_tdata)
         CH_PLUS:  tok_op = OP_ADD;
         CH_MINUS: tok_op = OP_SUB;
         CH_STAR:  tok_op = OP_MUL;
         default:  tok_op = OP_DIV;
      endcase
   end

   assign done_state = last_ff ? ST_FIN : ST_IDLE;
   assign div_shift  = {acc_ff[WORD_W-2:0], wb_ff[WORD_W-1]};

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      iter_in       = iter_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      negq_in       = negq_ff;
      tos_in        = tos_ff;
      acc_in        = acc_ff;
      wa_in         = wa_ff;
      wb_in         = wb_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      add_x         = acc_ff;
      add_y         = wa_ff;
      add_sub       = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      // result register drains on transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_in  = req_tlast;
               state_in = req_tlast ? ST_FIN : ST_IDLE;
               if (err_ff == STS_OK) begin
                  if (req_tuser) begin
                     err_in = STS_LENGTH;
                  end else if (is_digit) begin
                     if (count_ff >= CNT_FULL) begin
                        err_in = STS_OVERFLOW;
                     end else begin
                        // spill the old top into the RAM
                        wr_en    = (count_ff != '0);
                        tos_in   = WORD_W'(req_tdata - CH_ZERO);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end else if (!is_op) begin
                     err_in = STS_INVALID;
                  end else if (count_ff < CNT_W'(2)) begin
                     err_in = STS_UNDERFLOW;
                  end else begin
                     // fetch operand a, the entry below the top
                     rd_en    = 1'b1;
                     op_in    = tok_op;
                     state_in = ST_OPND;
                  end
               end
            end
         end

         ST_OPND: begin
            // rd_data is operand a, tos_ff is operand b
            unique case (op_ff) inside
               OP_ADD, OP_SUB: begin
                  add_x    = rd_data;
                  add_y    = tos_ff;
                  add_sub  = (op_ff == OP_SUB);
                  tos_in   = add_sum[WORD_W-1:0];
                  count_in = cnt_m1;
                  state_in = done_state;
               end
               OP_MUL: begin
                  acc_in   = '0;
                  wa_in    = rd_data;
                  wb_in    = tos_ff;
                  iter_in  = '0;
                  state_in = ST_ITER;
               end
               default: begin
                  if (tos_ff == '0) begin
                     err_in   = STS_DIVZERO;
                     state_in = done_state;
                  end else begin
                     acc_in   = '0;
                     wb_in    = rd_data;
                     wa_in    = tos_ff;
                     negq_in  = rd_data[WORD_W-1] ^ tos_ff[WORD_W-1];
                     state_in = ST_ABSA;
                  end
               end
            endcase
         end

         ST_ABSA: begin
            // magnitude of the dividend
            add_x   = '0;
            add_y   = wb_ff;
            add_sub = 1'b1;
            if (wb_ff[WORD_W-1]) begin
               wb_in = add_sum[WORD_W-1:0];
            end
            state_in = ST_ABSB;
         end

         ST_ABSB: begin
            // magnitude of the divisor
            add_x   = '0;
            add_y   = wa_ff;
            add_sub = 1'b1;
            if (wa_ff[WORD_W-1]) begin
               wa_in = add_sum[WORD_W-1:0];
            end
            iter_in  = '0;
            state_in = ST_ITER;
         end

         ST_ITER: begin
            iter_in = iter_ff + ITER_W'(1);
            if (op_ff == OP_MUL) begin
               // shift-add, multiplier LSB first
               add_x  = acc_ff;
               add_y  = wb_ff[0] ? wa_ff : '0;
               acc_in = add_sum[WORD_W-1:0];
               wa_in  = {wa_ff[WORD_W-2:0], 1'b0};
               wb_in  = {1'b0, wb_ff[WORD_W-1:1]};
               if (iter_ff == ITER_LAST) begin
                  tos_in   = add_sum[WORD_W-1:0];
                  count_in = cnt_m1;
                  state_in = done_state;
               end
            end else begin
               // restoring divide step, carry out means no borrow
               add_x   = div_shift;
               add_y   = wa_ff;
               add_sub = 1'b1;
               acc_in  = add_sum[WORD_W] ? add_sum[WORD_W-1:0] : div_shift;
               wb_in   = {wb_ff[WORD_W-2:0], add_sum[WORD_W]};
               if (iter_ff == ITER_LAST) begin
                  state_in = ST_FIX;
               end
            end
         end

         ST_FIX: begin
            // quotient sign
            add_x    = '0;
            add_y    = wb_ff;
            add_sub  = 1'b1;
            tos_in   = negq_ff ? add_sum[WORD_W-1:0] : wb_ff;
            count_in = cnt_m1;
            state_in = done_state;
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (err_ff != STS_OK) begin
                  rsp_status_in = err_ff;
                  rsp_value_in  = '0;
               end else if (count_ff != CNT_W'(1)) begin
                  rsp_status_in = STS_DEPTH;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = STS_OK;
                  rsp_value_in  = tos_ff;
               end
               count_in = '0;
               err_in   = STS_OK;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= STS_OK;
         iter_ff      <= '0;
         op_ff        <= OP_ADD;
         last_ff      <= 1'b0;
         negq_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         iter_ff      <= iter_in;
         op_ff        <= op_in;
         last_ff      <= last_in;
         negq_ff      <= negq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      tos_ff        <= tos_in;
      acc_ff        <= acc_in;
      wa_ff         <= wa_in;
      wb_ff         <= wb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/rpn_ram.sv
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/rpn_checker.sv
`include "rpn_stack_evaluator_defines.svh"

module rpn_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [rpn_pkg::TOKEN_W-1:0]  req_tdata,
   input logic                         req_tuser,
   input logic                         req_tlast,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [rpn_pkg::WORD_W-1:0]   rsp_tdata,
   input logic [rpn_pkg::STATUS_W-1:0] rsp_tuser
);

   import rpn_pkg::*;

   logic req_xfer;
   logic rsp_hold;
   logic rsp_fail;
   logic len_mid;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_hold = rsp_tvalid && !rsp_tready;
   assign rsp_fail = rsp_tvalid && (rsp_tuser != STS_OK);
   assign len_mid  = req_xfer && req_tuser && !req_tlast;

   // stalled result holds its value and status
   `RPN_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_hold,
                   rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
                   "result changed under stall")

   // failed expressions report a zero value
   `RPN_ASSERT_IMP(a_fail_zero, clock, reset, rsp_fail, rsp_tdata == '0,
                   "nonzero value with error status")

   // the final token always makes the block busy (ST_FIN) before the next token
   `RPN_ASSERT_NXT(a_last_busy, clock, reset, req_xfer && req_tlast, !req_tready,
                   "ready right after final token")

   // a bad-length token mid expression finishes in its own cycle
   `RPN_ASSERT_NXT(a_len_fast, clock, reset, len_mid, req_tready,
                   "busy after bad-length token")

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (.*);
